FILE: rtl/cfd_pkg.sv
// Shared constants and types for the sync-byte CAN frame deframer.
// Used by rtl/can_frame_deframer.sv; no dependencies.
package cfd_pkg;

  localparam int FRAME_BYTES = 18;
  localparam int STORE_DEPTH = FRAME_BYTES - 3;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int POS_W       = 5;
  localparam int SUM_LAST    = FRAME_BYTES - 3;
  localparam int END_POS     = FRAME_BYTES - 1;
  localparam int MAX_LEN     = 8;

  localparam logic [7:0] FIRST_SYNC_RST = 8'hAA;
  localparam logic [7:0] SECOND_SYNC_RST = 8'h55;
  localparam logic [7:0] END_BYTE_RST    = 8'h0D;
  localparam logic [7:0] EXT_CODE_RST    = 8'h01;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_SYNC  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_SYNC = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_BYTE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXT_CODE    = 3'd3;

  typedef enum logic [3:0] {
    PH_SEEK1 = 4'b0001,
    PH_SEEK2 = 4'b0010,
    PH_BODY  = 4'b0100,
    PH_END   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [31:0] frame_id;
    logic        is_extended;
    logic [3:0]  data_length;
    logic [63:0] payload;
  } result_t;

endpackage

FILE: rtl/can_frame_deframer.sv
// Deframer: one stream byte per beat, one decoded CAN frame per good frame.
// A frame result is registered when its end byte is accepted; a stalled output holds it in the skid stage.
// Input: one byte per cycle while the skid stage is empty; input stalls only while the skid stage is full.
// Reset (rst, synchronous): hunt for first sync, registers to defaults, output empty.
// Depends on rtl/cfd_pkg.sv.
module can_frame_deframer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [cfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [31:0]                   frame_id,
  output logic                          is_extended,
  output logic [3:0]                    data_length,
  output logic [63:0]                   payload
);

  logic [7:0] first_sync;
  logic [7:0] second_sync;
  logic [7:0] end_code;
  logic [7:0] ext_code;

  cfd_pkg::phase_t                phase;
  cfd_pkg::phase_t                phase_next;
  logic [cfd_pkg::POS_W-1:0]      byte_position;
  logic [cfd_pkg::POS_W-1:0]      pos_next;
  logic [cfd_pkg::POS_W-1:0]      pos_off;
  logic [7:0]                     running_sum;
  logic [7:0]                     sum_next;
  logic [7:0]                     frame_store [cfd_pkg::STORE_DEPTH];

  logic                           accept;
  logic                           hit;
  logic                           out_load;
  logic                           skid_valid;
  cfd_pkg::result_t               res;
  cfd_pkg::result_t               out_res;
  cfd_pkg::result_t               skid_res;

  assign accept   = in_valid && !in_stall;
  assign in_stall = skid_valid;
  assign out_load = !out_valid || !out_stall;
  assign pos_off  = byte_position - cfd_pkg::POS_W'(2);

  always_ff @(posedge clk) begin
    if (rst) begin
      first_sync  <= cfd_pkg::FIRST_SYNC_RST;
      second_sync <= cfd_pkg::SECOND_SYNC_RST;
      end_code    <= cfd_pkg::END_BYTE_RST;
      ext_code    <= cfd_pkg::EXT_CODE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        cfd_pkg::REG_FIRST_SYNC:  first_sync  <= cfg_data;
        cfd_pkg::REG_SECOND_SYNC: second_sync <= cfg_data;
        cfd_pkg::REG_END_BYTE:    end_code    <= cfg_data;
        cfd_pkg::REG_EXT_CODE:    ext_code    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next = phase;
    pos_next   = byte_position;
    sum_next   = running_sum;
    hit        = 1'b0;
    case (phase)
      cfd_pkg::PH_SEEK1: begin
        if (rx_byte == first_sync) phase_next = cfd_pkg::PH_SEEK2;
      end
      cfd_pkg::PH_SEEK2: begin
        if (rx_byte == second_sync) begin
          pos_next   = cfd_pkg::POS_W'(2);
          sum_next   = '0;
          phase_next = cfd_pkg::PH_BODY;
        end else if (rx_byte != first_sync) begin
          phase_next = cfd_pkg::PH_SEEK1;
        end
      end
      cfd_pkg::PH_BODY: begin
        if (byte_position <= cfd_pkg::POS_W'(cfd_pkg::SUM_LAST)) begin
          sum_next = running_sum + rx_byte;
        end
        pos_next = byte_position + cfd_pkg::POS_W'(1);
        if (pos_next >= cfd_pkg::POS_W'(cfd_pkg::END_POS)) phase_next = cfd_pkg::PH_END;
      end
      cfd_pkg::PH_END: begin
        hit        = (rx_byte == end_code) &&
                     (running_sum == frame_store[cfd_pkg::STORE_DEPTH-1]);
        phase_next = cfd_pkg::PH_SEEK1;
      end
      default: phase_next = cfd_pkg::PH_SEEK1;
    endcase
  end

  always_comb begin
    res.frame_id    = {frame_store[1], frame_store[2], frame_store[3], frame_store[4]};
    res.is_extended = (frame_store[0] == ext_code);
    res.data_length = (frame_store[5] > 8'(cfd_pkg::MAX_LEN)) ? 4'(cfd_pkg::MAX_LEN)
                                                              : frame_store[5][3:0];
    for (int i = 0; i < 8; i++) begin
      res.payload[8*i +: 8] = frame_store[6+i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= cfd_pkg::PH_SEEK1;
      byte_position <= '0;
      running_sum   <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      byte_position <= pos_next;
      running_sum   <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && phase == cfd_pkg::PH_BODY) begin
      frame_store[pos_off[cfd_pkg::STORE_AW-1:0]] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_load) begin
      if (skid_valid) begin
        out_res    <= skid_res;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (accept && hit) begin
        out_res   <= res;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (accept && hit) begin
      skid_res   <= res;
      skid_valid <= 1'b1;
    end
  end

  assign frame_id    = out_res.frame_id;
  assign is_extended = out_res.is_extended;
  assign data_length = out_res.data_length;
  assign payload     = out_res.payload;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a beat while output is empty");

  a_end_position: assert property (@(posedge clk) disable iff (rst)
    (phase == cfd_pkg::PH_END) |-> (byte_position == cfd_pkg::POS_W'(cfd_pkg::END_POS)))
    else $error("end phase reached at wrong byte position");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(phase) == cfd_pkg::PH_END && $past(accept)))
    else $error("result emitted outside end byte");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && out_stall))
    else $error("skid filled while output could load");

endmodule

FILE: verif/tb.sv
// Self-checking testbench for can_frame_deframer: directed frame table, then random traffic.
// A byte-level predictor and a queue of expected frames check every output beat.
// Depends on rtl/cfd_pkg.sv and rtl/can_frame_deframer.sv.
module tb;

  localparam int REG_COUNT      = 4;
  localparam int DIR_ROWS       = 10;
  localparam int EQUAL_SYNC_ROW = 8;
  localparam int SETTLE_CYCLES  = 8;
  localparam int LONG_HOLD      = 400;
  localparam int PRESSURE_FRAMES = 8;
  localparam int TRAFFIC_BYTES  = 100;
  localparam int TIMEOUT_UNITS  = 2_000_000;

  typedef enum {LEAD_NONE, LEAD_RESYNC, LEAD_BREAK} lead_t;

  typedef struct {
    lead_t             lead;
    logic [7:0]        ftype;
    logic [31:0]       id;
    logic [7:0]        len;
    logic [63:0]       pay;
    logic [7:0]        flip;
    bit                end_bad;
    bit                typed;
    bit                yields;
    cfd_pkg::result_t  want;
  } frame_row_t;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          cfg_write;
  logic [cfd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [7:0]                    cfg_data;
  logic                          in_valid;
  logic                          in_stall;
  logic [7:0]                    rx_byte;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [31:0]                   frame_id;
  logic                          is_extended;
  logic [3:0]                    data_length;
  logic [63:0]                   payload;

  logic [7:0]       r_first, r_second, r_end, r_ext;
  cfd_pkg::phase_t  ph;
  logic [4:0]       pos;
  logic [7:0]       store [cfd_pkg::STORE_DEPTH];
  logic [7:0]       sum;

  cfd_pkg::result_t pending_frames [$];
  int      errors = 0;
  int      bytes_accepted = 0;
  int      tx_idle_pct = 0;
  int      rx_idle_pct = 0;
  int      hold_left = 0;
  bit      hand_typed = 1'b0;

  frame_row_t dir_rows [DIR_ROWS] = '{
    '{LEAD_NONE, 8'h01, 32'h0000_0000, 8'h00, 64'h0, 8'h00, 1'b0, 1'b1, 1'b1,
      '{32'h0000_0000, 1'b1, 4'd0, 64'h0}},
    '{LEAD_NONE, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b1, 1'b1,
      '{32'hFFFF_FFFF, 1'b0, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF}},
    '{LEAD_NONE, 8'h00, 32'h1234_5678, 8'h09, 64'h0123_4567_89AB_CDEF, 8'h00, 1'b0, 1'b1, 1'b1,
      '{32'h1234_5678, 1'b0, 4'd8, 64'h0123_4567_89AB_CDEF}},
    '{LEAD_NONE, 8'h01, 32'h1FFF_FFFF, 8'h03, 64'hDEAD_BEEF_0000_0311, 8'h00, 1'b0, 1'b1, 1'b1,
      '{32'h1FFF_FFFF, 1'b1, 4'd3, 64'hDEAD_BEEF_0000_0311}},
    '{LEAD_NONE, 8'h01, 32'h0000_0123, 8'h08, 64'h1122_3344_5566_7788, 8'h80, 1'b0, 1'b1, 1'b0,
      '0},
    '{LEAD_NONE, 8'h00, 32'h0000_0456, 8'h08, 64'h8877_6655_4433_2211, 8'h00, 1'b1, 1'b1, 1'b0,
      '0},
    '{LEAD_RESYNC, 8'h01, 32'h0000_07FF, 8'h08, 64'hC3A5_5A3C_0F1E_2D4B, 8'h00, 1'b0, 1'b0, 1'b0,
      '0},
    '{LEAD_BREAK, 8'hAA, 32'hAA55_AA55, 8'h55, 64'h0D0D_55AA_0D55_AA0D, 8'h00, 1'b0, 1'b0, 1'b0,
      '0},
    '{LEAD_NONE, 8'h00, 32'h3C3C_3C3C, 8'h08, 64'hFF3C_FF3C_0000_FFFF, 8'h00, 1'b0, 1'b0, 1'b0,
      '0},
    '{LEAD_RESYNC, 8'h3C, 32'h0ABC_DEF0, 8'h02, 64'h3C3C_3C3C_3C3C_3C3C, 8'h00, 1'b0, 1'b0, 1'b0,
      '0}
  };

  can_frame_deframer DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .frame_id    (frame_id),
    .is_extended (is_extended),
    .data_length (data_length),
    .payload     (payload)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit deframe_byte(input logic [7:0] b, output cfd_pkg::result_t r);
    logic [7:0] len;
    r = '0;
    deframe_byte = 1'b0;
    case (ph)
      cfd_pkg::PH_SEEK1: begin
        if (b == r_first) ph = cfd_pkg::PH_SEEK2;
      end
      cfd_pkg::PH_SEEK2: begin
        if (b == r_second) begin
          pos = 5'd2;
          sum = '0;
          ph = cfd_pkg::PH_BODY;
        end else if (b != r_first) begin
          ph = cfd_pkg::PH_SEEK1;
        end
      end
      cfd_pkg::PH_BODY: begin
        store[pos - 2] = b;
        if (pos <= cfd_pkg::SUM_LAST) sum += b;
        pos++;
        if (pos >= cfd_pkg::END_POS) ph = cfd_pkg::PH_END;
      end
      default: begin
        if (b == r_end && sum == store[cfd_pkg::STORE_DEPTH - 1]) begin
          r.frame_id = {store[1], store[2], store[3], store[4]};
          r.is_extended = (store[0] == r_ext);
          len = (store[5] > cfd_pkg::MAX_LEN) ? 8'(cfd_pkg::MAX_LEN) : store[5];
          r.data_length = len[3:0];
          for (int i = 0; i < cfd_pkg::MAX_LEN; i++) r.payload[8*i +: 8] = store[6 + i];
          deframe_byte = 1'b1;
        end
        ph = cfd_pkg::PH_SEEK1;
      end
    endcase
  endfunction

  function automatic logic [7:0] junk_byte();
    logic [7:0] j;
    do j = 8'($urandom_range(255)); while (j == r_first || j == r_second);
    return j;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    cfd_pkg::result_t r;
    bit               got;
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_accepted++;
    got = deframe_byte(b, r);
    if (got && !hand_typed) pending_frames.push_back(r);
  endtask

  task automatic send_frame(input lead_t lead, input logic [7:0] ftype, input logic [31:0] id,
                            input logic [7:0] len, input logic [63:0] pay,
                            input logic [7:0] flip, input bit end_bad, input int cut);
    logic [7:0] f [cfd_pkg::FRAME_BYTES];
    logic [7:0] s;
    f[0] = r_first;
    f[1] = r_second;
    f[2] = ftype;
    f[3] = id[31:24];
    f[4] = id[23:16];
    f[5] = id[15:8];
    f[6] = id[7:0];
    f[7] = len;
    for (int i = 0; i < cfd_pkg::MAX_LEN; i++) f[8 + i] = pay[8*i +: 8];
    s = '0;
    for (int i = 2; i <= cfd_pkg::SUM_LAST; i++) s += f[i];
    f[cfd_pkg::END_POS - 1] = s ^ flip;
    f[cfd_pkg::END_POS] = end_bad ? ~r_end : r_end;
    if (lead == LEAD_RESYNC) begin
      send_byte(r_first);
    end else if (lead == LEAD_BREAK) begin
      send_byte(r_first);
      send_byte(junk_byte());
    end
    for (int i = 0; i < cut; i++) send_byte(f[i]);
  endtask

  task automatic random_frame();
    lead_t      lead;
    logic [7:0] ftype;
    logic [7:0] len;
    logic [7:0] flip;
    bit         end_bad;
    int         cut;
    int         pick;
    if ($urandom_range(5) == 0) repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
    pick = $urandom_range(9);
    lead = (pick == 0) ? LEAD_RESYNC : (pick == 1) ? LEAD_BREAK : LEAD_NONE;
    ftype = $urandom_range(1) ? r_ext : 8'($urandom_range(255));
    len = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                   : 8'($urandom_range(cfd_pkg::MAX_LEN));
    flip = ($urandom_range(7) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
    end_bad = ($urandom_range(11) == 0);
    cut = ($urandom_range(11) == 0) ? $urandom_range(1, cfd_pkg::FRAME_BYTES - 1)
                                    : cfd_pkg::FRAME_BYTES;
    send_frame(lead, ftype, $urandom, len, {$urandom, $urandom}, flip, end_bad, cut);
  endtask

  task automatic run_traffic(input int n);
    int start;
    start = bytes_accepted;
    while (bytes_accepted - start < n) random_frame();
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [cfd_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      cfd_pkg::REG_FIRST_SYNC:  r_first = val;
      cfd_pkg::REG_SECOND_SYNC: r_second = val;
      cfd_pkg::REG_END_BYTE:    r_end = val;
      cfd_pkg::REG_EXT_CODE:    r_ext = val;
      default: ;
    endcase
  endtask

  task automatic set_all(input logic [7:0] first, input logic [7:0] second,
                         input logic [7:0] close, input logic [7:0] ext);
    set_reg(cfd_pkg::REG_FIRST_SYNC, first);
    set_reg(cfd_pkg::REG_SECOND_SYNC, second);
    set_reg(cfd_pkg::REG_END_BYTE, close);
    set_reg(cfd_pkg::REG_EXT_CODE, ext);
  endtask

  always @(posedge clk) begin : check_frames
    cfd_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_frames.size() == 0) begin
        $error("unexpected frame: frame_id %h payload %h", frame_id, payload);
        errors++;
      end else begin
        want = pending_frames.pop_front();
        if (frame_id !== want.frame_id) begin
          $error("frame_id: expected %h, got %h", want.frame_id, frame_id);
          errors++;
        end
        if (is_extended !== want.is_extended) begin
          $error("is_extended: expected %b, got %b", want.is_extended, is_extended);
          errors++;
        end
        if (data_length !== want.data_length) begin
          $error("data_length: expected %0d, got %0d", want.data_length, data_length);
          errors++;
        end
        if (payload !== want.payload) begin
          $error("payload: expected %h, got %h", want.payload, payload);
          errors++;
        end
      end
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct);
    end
  end

  initial begin
    #(TIMEOUT_UNITS);
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    logic [7:0] a;
    logic [7:0] c;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = cfd_pkg::REG_FIRST_SYNC;
    cfg_data = '0;
    in_valid = 1'b0;
    rx_byte = '0;
    r_first = cfd_pkg::FIRST_SYNC_RST;
    r_second = cfd_pkg::SECOND_SYNC_RST;
    r_end = cfd_pkg::END_BYTE_RST;
    r_ext = cfd_pkg::EXT_CODE_RST;
    ph = cfd_pkg::PH_SEEK1;
    pos = '0;
    sum = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 21;
    rx_idle_pct = 68;
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == EQUAL_SYNC_ROW) begin
        settle();
        set_all(8'h3C, 8'h3C, 8'hFF, 8'h00);
        for (int j = REG_COUNT; j < (1 << cfd_pkg::CFG_IDX_W); j++) begin
          set_reg(cfd_pkg::CFG_IDX_W'(j), 8'hEE);
        end
      end
      hand_typed = dir_rows[i].typed;
      send_frame(dir_rows[i].lead, dir_rows[i].ftype, dir_rows[i].id, dir_rows[i].len,
                 dir_rows[i].pay, dir_rows[i].flip, dir_rows[i].end_bad,
                 cfd_pkg::FRAME_BYTES);
      if (dir_rows[i].typed && dir_rows[i].yields) pending_frames.push_back(dir_rows[i].want);
      hand_typed = 1'b0;
    end

    settle();
    set_all(cfd_pkg::FIRST_SYNC_RST, cfd_pkg::SECOND_SYNC_RST, cfd_pkg::END_BYTE_RST,
            cfd_pkg::EXT_CODE_RST);
    run_traffic(TRAFFIC_BYTES);

    settle();
    tx_idle_pct = 68;
    rx_idle_pct = 21;
    a = 8'($urandom_range(255));
    do c = 8'($urandom_range(255)); while (c == a);
    set_all(a, c, 8'($urandom_range(255)), 8'($urandom_range(255)));
    run_traffic(TRAFFIC_BYTES);

    settle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_all(8'h00, 8'hFF, 8'h00, 8'hFF);
    hold_left = LONG_HOLD;
    repeat (PRESSURE_FRAMES)
      send_frame(LEAD_NONE, r_ext, $urandom, 8'(cfd_pkg::MAX_LEN), {$urandom, $urandom},
                 8'h00, 1'b0, cfd_pkg::FRAME_BYTES);
    run_traffic(TRAFFIC_BYTES);

    settle();
    set_all(8'hFF, 8'h00, 8'hFF, 8'h00);
    run_traffic(TRAFFIC_BYTES);

    settle();
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
